>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hdl/qscc_pkg.sv
package qscc_pkg;

  localparam int unsigned Depth  = 1024;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned StackD = AddrW + 1;
  localparam int unsigned SpW    = $clog2(StackD + 1);

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpLoad  = 2'd1,
    OpSort  = 2'd2,
    OpRead  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PivFirst  = 2'd0,
    PivLast   = 2'd1,
    PivMedian = 2'd2,
    PivSpare  = 2'd3
  } piv_e;

  typedef enum logic {
    KindSort = 1'b0,
    KindRead = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [9:0]         index;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] data;
    logic [31:0]        comparison_count;
    logic               index_valid;
  } out_item_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic             rd;
    logic [AddrW-1:0] raddr;
    logic             wr;
    logic [AddrW-1:0] waddr;
    logic [31:0]      wdata;
  } mem_req_t;

endpackage

>>> hdl/qscc_store.sv
module qscc_store (
  input  logic                clk_i,
  input  qscc_pkg::mem_req_t  req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem_q [qscc_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

>>> hdl/qscc_seq.sv
module qscc_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  qscc_pkg::in_item_t        item_i,
  input  logic [1:0]                pivot_mode_i,
  input  logic [31:0]               rdata_i,
  output qscc_pkg::mem_req_t        req_o,
  output logic                      busy_o,
  output logic                      strobe_o,
  output qscc_pkg::out_item_t       result_o
);

  localparam int unsigned AW = qscc_pkg::AddrW;
  localparam int unsigned CW = qscc_pkg::CountW;
  localparam int unsigned SW = qscc_pkg::SpW;

  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StRdWait = 15'b000000000000010,
    StPop    = 15'b000000000000100,
    StMedRdA = 15'b000000000001000,
    StMedRdB = 15'b000000000010000,
    StMedRdC = 15'b000000000100000,
    StMedPk  = 15'b000000001000000,
    StSwRdLo = 15'b000000010000000,
    StSwRdX  = 15'b000000100000000,
    StSwWr   = 15'b000001000000000,
    StScan   = 15'b000010000000000,
    StCmp    = 15'b000100000000000,
    StFinRd  = 15'b001000000000000,
    StFinWr  = 15'b010000000000000,
    StDone   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   total_q, total_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, x_q, x_d;
  logic [31:0]   piv_q, piv_d, va_q, va_d, vb_q, vb_d, tmp_q, tmp_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [1:0]    rdx_q, rdx_d;  // pivot placement phase
  logic          rdv_q, rdv_d;
  logic          strobe_q, strobe_d;
  qscc_pkg::out_item_t res_q, res_d;

  // Range stack of pending lo/hi pairs.
  logic [2*AW-1:0] stk_q [qscc_pkg::StackD];
  logic            push;
  logic [2*AW-1:0] push_val;

  // Scan comparator: signed a <= b.
  logic signed [31:0] cmp_a, cmp_b;
  logic               cmp_le;
  assign cmp_le = cmp_a <= cmp_b;

  logic [32:0] sum;
  logic [AW-1:0] sub_hl, p, left_len, right_len;
  logic          mode_last, mode_med;

  assign mode_last = pivot_mode_i == qscc_pkg::PivLast;
  assign mode_med  = pivot_mode_i == qscc_pkg::PivMedian;

  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_q[sp_q[$clog2(qscc_pkg::StackD)-1:0]] <= push_val;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    sp_d     = sp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    i_d      = i_q;
    j_d      = j_q;
    x_d      = x_q;
    piv_d    = piv_q;
    va_d     = va_q;
    vb_d     = vb_q;
    tmp_d    = tmp_q;
    mid_d    = mid_q;
    rdx_d    = 2'd0;
    rdv_d    = rdv_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    req_o    = '0;
    push     = 1'b0;
    push_val = '0;
    cmp_a    = va_q;
    cmp_b    = vb_q;
    sub_hl   = hi_q - lo_q;
    sum      = {1'b0, total_q} + {{(33-AW){1'b0}}, sub_hl};
    p        = i_q - AW'(1);
    left_len = p - lo_q;
    right_len = hi_q - p;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (qscc_pkg::op_e'(item_i.opcode))
            qscc_pkg::OpClear: begin
              count_d = '0;
              total_d = '0;
            end
            qscc_pkg::OpLoad: begin
              if (count_q < CW'(qscc_pkg::Depth)) begin
                req_o.wr    = 1'b1;
                req_o.waddr = count_q[AW-1:0];
                req_o.wdata = item_i.value;
                count_d     = count_q + CW'(1);
              end
            end
            qscc_pkg::OpRead: begin
              req_o.rd    = 1'b1;
              req_o.raddr = item_i.index[AW-1:0];
              rdv_d       = CW'(item_i.index) < count_q;
              state_d     = StRdWait;
            end
            qscc_pkg::OpSort: begin
              if (count_q < CW'(2)) begin
                state_d = StDone;
              end else begin
                lo_d    = '0;
                hi_d    = AW'(count_q - CW'(1));
                state_d = StPop;
              end
            end
            default: ;
          endcase
        end
      end
      StRdWait: begin
        strobe_d               = 1'b1;
        res_d.result_kind      = qscc_pkg::KindRead;
        res_d.data             = rdv_q ? rdata_i : '0;
        res_d.comparison_count = '0;
        res_d.index_valid      = rdv_q;
        state_d                = StIdle;
      end
      StPop: begin
        // Partition the current range, pop the next one, or finish when the stack is empty.
        if (lo_q < hi_q) begin
          total_d = sum[32] ? '1 : sum[31:0];
          mid_d   = lo_q + (sub_hl >> 1);
          if (mode_med) begin
            req_o.rd = 1'b1; req_o.raddr = lo_q;
            state_d  = StMedRdA;
          end else begin
            x_d      = mode_last ? hi_q : lo_q;
            req_o.rd = 1'b1; req_o.raddr = lo_q;
            state_d  = StSwRdLo;
          end
        end else if (sp_q != '0) begin
          sp_d = sp_q - SW'(1);
          {lo_d, hi_d} = stk_q[sp_d[$clog2(qscc_pkg::StackD)-1:0]];
        end else begin
          state_d = StDone;
        end
      end
      StMedRdA: begin
        va_d = rdata_i;
        req_o.rd = 1'b1; req_o.raddr = mid_q;
        state_d = StMedRdB;
      end
      StMedRdB: begin
        vb_d = rdata_i;
        req_o.rd = 1'b1; req_o.raddr = hi_q;
        state_d = StMedRdC;
      end
      StMedRdC: begin
        tmp_d = rdata_i;
        state_d = StMedPk;
      end
      StMedPk: begin
        // Median of three with the strict tie rules.
        if ($signed(va_q) < $signed(vb_q)) begin
          if ($signed(vb_q) < $signed(tmp_q)) x_d = mid_q;
          else if ($signed(va_q) < $signed(tmp_q)) x_d = hi_q;
          else x_d = lo_q;
        end else begin
          if ($signed(vb_q) > $signed(tmp_q)) x_d = mid_q;
          else if ($signed(va_q) > $signed(tmp_q)) x_d = hi_q;
          else x_d = lo_q;
        end
        req_o.rd = 1'b1; req_o.raddr = lo_q;
        state_d = StSwRdLo;
      end
      StSwRdLo: begin
        va_d = rdata_i;
        req_o.rd = 1'b1; req_o.raddr = x_q;
        state_d = StSwRdX;
      end
      StSwRdX: begin
        // Pivot swap: store[lo] gets store[x].
        piv_d = rdata_i;
        req_o.wr = 1'b1; req_o.waddr = lo_q; req_o.wdata = rdata_i;
        state_d = StSwWr;
      end
      StSwWr: begin
        req_o.wr = 1'b1; req_o.waddr = x_q; req_o.wdata = va_q;
        i_d = lo_q + AW'(1);
        j_d = lo_q + AW'(1);
        state_d = StScan;
      end
      StScan: begin
        req_o.rd = 1'b1; req_o.raddr = j_q;
        state_d = StCmp;
      end
      StCmp: begin
        // rdata is store[j]; on <= pivot swap with store[i].
        cmp_a = rdata_i;
        cmp_b = piv_q;
        if (cmp_le) begin
          tmp_d = rdata_i;
          req_o.rd = 1'b1; req_o.raddr = i_q;
          state_d = StFinRd;
        end else if (j_q == hi_q) begin
          req_o.rd = 1'b1; req_o.raddr = p;
          x_d = p;
          state_d = StFinWr;
          j_d = '1;
        end else begin
          j_d = j_q + AW'(1);
          state_d = StScan;
        end
      end
      StFinRd: begin
        // Write both halves of the i/j swap, one per cycle.
        req_o.wr = 1'b1; req_o.waddr = j_q; req_o.wdata = rdata_i;
        va_d = tmp_q;
        state_d = StFinWr;
        x_d = i_q;
      end
      StFinWr: begin
        if (x_q == i_q) begin
          // second half of scan swap
          req_o.wr = 1'b1; req_o.waddr = i_q; req_o.wdata = va_q;
          i_d = i_q + AW'(1);
          if (j_q == hi_q) begin
            x_d = i_q;
            j_d = '1;
            tmp_d = '0;
            state_d = StFinWr;
            rdx_d = 2'd1;
          end else begin
            j_d = j_q + AW'(1);
            state_d = StScan;
          end
        end else if (rdx_q == 2'd0 && x_q == p) begin
          // rdata = store[p]; move to lo, pivot to p
          req_o.wr = 1'b1; req_o.waddr = lo_q; req_o.wdata = rdata_i;
          va_d = piv_q;
          rdx_d = 2'd2;
          state_d = StFinWr;
        end else if (rdx_q == 2'd1) begin
          // store[p] now holds the element just swapped in, still in va
          req_o.wr = 1'b1; req_o.waddr = lo_q; req_o.wdata = va_q;
          rdx_d = 2'd2;
          state_d = StFinWr;
        end else begin
          req_o.wr = 1'b1; req_o.waddr = p; req_o.wdata = piv_q;
          if (left_len > right_len) begin
            if (p - AW'(1) > lo_q && p != lo_q) begin
              push = 1'b1; push_val = {lo_q, p - AW'(1)};
              sp_d = sp_q + SW'(1);
            end
            // pivot at the top end closes the range
            lo_d = (p == hi_q) ? hi_q : p + AW'(1);
          end else begin
            if (p != hi_q && hi_q > p + AW'(1)) begin
              push = 1'b1; push_val = {p + AW'(1), hi_q};
              sp_d = sp_q + SW'(1);
            end
            hi_d = (p == '0) ? '0 : p - AW'(1);
            if (p == '0) lo_d = AW'(1);
          end
          state_d = StPop;
        end
      end
      StDone: begin
        strobe_d               = 1'b1;
        res_d.result_kind      = qscc_pkg::KindSort;
        res_d.data             = '0;
        res_d.comparison_count = total_q;
        res_d.index_valid      = 1'b0;
        sp_d                   = '0;
        state_d                = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      total_q  <= '0;
      sp_q     <= '0;
      strobe_q <= 1'b0;
      rdx_q    <= 2'd0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      sp_q     <= sp_d;
      strobe_q <= strobe_d;
      rdx_q    <= rdx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    x_q   <= x_d;
    piv_q <= piv_d;
    va_q  <= va_d;
    vb_q  <= vb_d;
    tmp_q <= tmp_d;
    mid_q <= mid_d;
    rdv_q <= rdv_d;
    res_q <= res_d;
  end

  assign busy_o   = state_q != StIdle;
  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

>>> hdl/quicksort_comparison_counter.sv
// Loads and clears complete in the idle state; a read passes through the read-wait state.
// A sort walks partitions through a signed compare and the store's read and
// write ports, scanning each element against the pivot and popping ranges
// from a stack; busy stays high until the sort result strobes.
// Results strobe for one cycle; the receiver cannot stall.
// Reset (async, active low) empties the store count, total and stack.
module quicksort_comparison_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  qscc_pkg::in_item_t   item_i,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,
  output logic                 strobe,
  output qscc_pkg::out_item_t  result_o
);

  qscc_pkg::mem_req_t req;
  logic [31:0]        rdata;
  logic [1:0]         mode_q;

  // Hold pivot mode; the user must write it only while idle (not enforced here).
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qscc_pkg::PivMedian;
    end else if (cfg_valid) begin
      mode_q <= cfg_data;
    end
  end

  logic start_ok;
  assign start_ok = start & ~busy;

  qscc_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_i      (start_ok),
    .item_i,
    .pivot_mode_i (mode_q),
    .rdata_i      (rdata),
    .req_o        (req),
    .busy_o       (busy),
    .strobe_o     (strobe),
    .result_o
  );

  qscc_store u_store (
    .clk_i,
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule

>>> hdl/qscc_checker.sv
`include "assert_macros.svh"

module qscc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                busy,
  input logic                strobe,
  input qscc_pkg::out_item_t result_o
);

  logic rd_res, rd_miss, sort_res, sort_clean;

  assign rd_res     = strobe && (result_o.result_kind == qscc_pkg::KindRead);
  assign rd_miss    = rd_res && !result_o.index_valid;
  assign sort_res   = strobe && (result_o.result_kind == qscc_pkg::KindSort);
  assign sort_clean = !result_o.index_valid && (result_o.data == 0);

  `CHK_ASSERT(a_read_zero, clk_i, rst_ni, rd_miss |-> result_o.data == 0, "invalid read not zero")
  `CHK_ASSERT(a_read_cnt, clk_i, rst_ni, rd_res |-> result_o.comparison_count == 0, "read count")
  `CHK_ASSERT(a_sort_flags, clk_i, rst_ni, sort_res |-> sort_clean, "sort fields")
  `CHK_ASSERT(a_no_dbl, clk_i, rst_ni, strobe |=> !strobe, "strobe twice")
  `CHK_ASSERT(a_idle_out, clk_i, rst_ni, strobe |-> !busy, "busy during result")

endmodule

bind quicksort_comparison_counter qscc_checker u_chk (.*);
